FILE: src/bpa_pkg.sv
// Shared types, constants and codes for the bitmap pool allocator.
package bpa_pkg;

    localparam int MAX_UNITS  = 256;
    localparam int IDX_W      = $clog2(MAX_UNITS);
    localparam int CNT_W      = $clog2(MAX_UNITS + 1);
    localparam int ADDR_W     = 48;
    localparam int UNIT_W     = 21;
    localparam int SPAN_W     = CNT_W + UNIT_W;
    localparam int DIV_W      = UNIT_W + IDX_W;
    localparam int PROD_W     = IDX_W + UNIT_W;
    localparam int CHUNK_BITS = 32;
    localparam int NUM_CHUNKS = MAX_UNITS / CHUNK_BITS;
    localparam int CHUNK_W    = $clog2(NUM_CHUNKS);
    localparam int PE_W       = $clog2(CHUNK_BITS);
    localparam int STEP_W     = $clog2(IDX_W);

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNITS_IN_USE = 2'd2;

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(64);
    localparam logic [CNT_W-1:0]  CAP_RESET  = CNT_W'(256);

    typedef enum logic [1:0] {
        REQ_ALLOC     = 2'd0,
        REQ_FREE_ADDR = 2'd1,
        REQ_FREE_IDX  = 2'd2,
        REQ_CLEAR     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_ADDR_RANGE = 2'd2,
        ST_IDX_RANGE  = 2'd3
    } t_status;

    // effective configuration: zero unit reads as one, capacity clamped
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [UNIT_W-1:0] unit;
        logic [CNT_W-1:0]  cap;
    } t_cfg;

    // classified request passed from front to back
    typedef struct packed {
        t_req              req;
        logic              below;
        logic [ADDR_W-1:0] offset;
        logic [IDX_W-1:0]  fidx;
        logic              idx_oor;
    } t_cmd;

endpackage

FILE: src/bpa_front.sv
// Front end: accepts requests and classifies them into queue commands.
module bpa_front (
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [1:0]              i_req_type,
    input  logic [bpa_pkg::ADDR_W-1:0] i_free_address,
    input  logic [bpa_pkg::IDX_W-1:0]  i_free_index,
    input  bpa_pkg::t_cfg           i_cfg,
    input  logic                    i_q_full,
    output logic                    o_push,
    output bpa_pkg::t_cmd           o_cmd
);

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        o_cmd.req     = bpa_pkg::t_req'(i_req_type);
        o_cmd.below   = i_free_address < i_cfg.base;
        o_cmd.offset  = i_free_address - i_cfg.base;
        o_cmd.fidx    = i_free_index;
        o_cmd.idx_oor = {1'b0, i_free_index} >= i_cfg.cap;
    end

endmodule

FILE: src/bpa_queue.sv
// Two-entry command queue between front and back.
module bpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpa_pkg::t_cmd i_push_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output bpa_pkg::t_cmd o_pop_data
);

    bpa_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full     = r_count == 2'd2;
    assign o_empty    = r_count == 2'd0;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/bpa_back.sv
// Back end: free bitmap, first-free scan, address divider and result register.
module bpa_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpa_pkg::t_cfg              i_cfg,
    input  logic                       i_q_empty,
    input  bpa_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [1:0]                 o_status,
    output logic [bpa_pkg::ADDR_W-1:0] o_unit_address,
    output logic [bpa_pkg::IDX_W-1:0]  o_unit_index,
    output logic [bpa_pkg::CNT_W-1:0]  o_used_units
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SCAN, S_MUL, S_ADD, S_DIV, S_REL, S_EMIT
    } t_state;

    t_state                         r_state;
    bpa_pkg::t_cmd                  r_cmd;
    logic [bpa_pkg::MAX_UNITS-1:0]  r_free_map;
    logic [bpa_pkg::CNT_W-1:0]      r_used;
    logic [bpa_pkg::SPAN_W-1:0]     r_span;
    logic [bpa_pkg::CHUNK_W-1:0]    r_chunk;
    logic [bpa_pkg::IDX_W-1:0]      r_found;
    logic [bpa_pkg::PROD_W-1:0]     r_prod;
    logic [bpa_pkg::DIV_W-1:0]      r_rem;
    logic [bpa_pkg::DIV_W-1:0]      r_dvs;
    logic [bpa_pkg::IDX_W-1:0]      r_quo;
    logic [bpa_pkg::STEP_W-1:0]     r_step;
    bpa_pkg::t_status               r_res_status;
    logic [bpa_pkg::ADDR_W-1:0]     r_res_addr;
    logic [bpa_pkg::IDX_W-1:0]      r_res_idx;
    logic                           r_out_valid;
    bpa_pkg::t_status               r_out_status;
    logic [bpa_pkg::ADDR_W-1:0]     r_out_addr;
    logic [bpa_pkg::IDX_W-1:0]      r_out_idx;
    logic [bpa_pkg::CNT_W-1:0]      r_out_used;

    logic [bpa_pkg::CHUNK_BITS-1:0] w_chunk_free;
    logic [bpa_pkg::PE_W-1:0]       w_pe;
    logic                           w_out_free;

    assign o_pop          = (r_state == S_IDLE) && !i_q_empty;
    assign w_out_free     = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_status       = r_out_status;
    assign o_unit_address = r_out_addr;
    assign o_unit_index   = r_out_idx;
    assign o_used_units   = r_out_used;

    // current 32-unit slice of the map, limited to the managed capacity
    always_comb begin
        for (int j = 0; j < bpa_pkg::CHUNK_BITS; j++) begin
            w_chunk_free[j] = r_free_map[{r_chunk, j[bpa_pkg::PE_W-1:0]}]
                && ({1'b0, r_chunk, j[bpa_pkg::PE_W-1:0]} < i_cfg.cap);
        end
        w_pe = '0;
        for (int j = bpa_pkg::CHUNK_BITS - 1; j >= 0; j--) begin
            if (w_chunk_free[j]) begin
                w_pe = j[bpa_pkg::PE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_map  <= '1;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_EMIT reloads the output register itself
            if (i_m_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_span <= i_cfg.cap * i_cfg.unit;
                    if (!i_q_empty) begin
                        r_cmd        <= i_cmd;
                        r_res_status <= bpa_pkg::ST_OK;
                        r_res_addr   <= '0;
                        r_res_idx    <= '0;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd.req)
                        bpa_pkg::REQ_ALLOC: begin
                            r_chunk <= '0;
                            r_state <= S_SCAN;
                        end
                        bpa_pkg::REQ_FREE_ADDR: begin
                            if (r_cmd.below ||
                                r_cmd.offset >= bpa_pkg::ADDR_W'(r_span)) begin
                                r_res_status <= bpa_pkg::ST_ADDR_RANGE;
                                r_state      <= S_EMIT;
                            end else begin
                                r_rem   <= r_cmd.offset[bpa_pkg::DIV_W-1:0];
                                r_dvs   <= bpa_pkg::DIV_W'({i_cfg.unit,
                                           (bpa_pkg::IDX_W-1)'(0)});
                                r_quo   <= '0;
                                r_step  <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        bpa_pkg::REQ_FREE_IDX: begin
                            if (r_cmd.idx_oor) begin
                                r_res_status <= bpa_pkg::ST_IDX_RANGE;
                            end else begin
                                r_res_idx <= r_cmd.fidx;
                                if (!r_free_map[r_cmd.fidx]) begin
                                    r_free_map[r_cmd.fidx] <= 1'b1;
                                    if (r_used != '0) begin
                                        r_used <= r_used - 1'b1;
                                    end
                                end
                            end
                            r_state <= S_EMIT;
                        end
                        default: begin
                            r_free_map <= '1;
                            r_used     <= '0;
                            r_state    <= S_EMIT;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (w_chunk_free != '0) begin
                        r_found                 <= {r_chunk, w_pe};
                        r_free_map[{r_chunk, w_pe}] <= 1'b0;
                        r_used                  <= r_used + 1'b1;
                        r_state                 <= S_MUL;
                    end else if (r_chunk == bpa_pkg::CHUNK_W'(bpa_pkg::NUM_CHUNKS - 1)) begin
                        r_res_status <= bpa_pkg::ST_FULL;
                        r_state      <= S_EMIT;
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_found * i_cfg.unit;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_res_addr <= i_cfg.base + bpa_pkg::ADDR_W'(r_prod);
                    r_res_idx  <= r_found;
                    r_state    <= S_EMIT;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (r_rem >= r_dvs) begin
                        r_rem <= r_rem - r_dvs;
                        r_quo <= {r_quo[bpa_pkg::IDX_W-2:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[bpa_pkg::IDX_W-2:0], 1'b0};
                    end
                    r_dvs  <= r_dvs >> 1;
                    r_step <= r_step + 1'b1;
                    if (r_step == bpa_pkg::STEP_W'(bpa_pkg::IDX_W - 1)) begin
                        r_state <= S_REL;
                    end
                end
                S_REL: begin
                    r_res_idx <= r_quo;
                    if (!r_free_map[r_quo]) begin
                        r_free_map[r_quo] <= 1'b1;
                        if (r_used != '0) begin
                            r_used <= r_used - 1'b1;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr   <= r_res_addr;
                        r_out_idx    <= r_res_idx;
                        r_out_used   <= r_used;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/bitmap_pool_allocator_top.sv
// Top level of the bitmap pool allocator: config registers, front, queue, back.
// Flow: free by index, clear and range errors go through S_IDLE, S_EXEC and S_EMIT;
// allocate scans the map one 32-unit slice at a time in S_SCAN, then multiplies and
// adds in S_MUL and S_ADD; a full pool goes from S_SCAN to S_EMIT; free by address
// runs the 8-step restoring divider in S_DIV, then S_REL. The back end takes the next
// request the cycle after a result goes out, so requests are handled one at a time;
// a waiting result stalls it while the two-entry queue accepts. Synchronous active-low
// reset empties the queue, frees every unit, zeroes the count and restores config.
module bitmap_pool_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // [47:0] free_address, [55:48] free_index
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [47:0] unit_address, [55:48] unit_index,
                                     // [64:56] used_units, [71:65] zero
    output logic [1:0]  o_m_tuser,   // [1:0] status
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic [bpa_pkg::ADDR_W-1:0] r_pool_base;
    logic [bpa_pkg::UNIT_W-1:0] r_unit_bytes;
    logic [bpa_pkg::CNT_W-1:0]  r_units_in_use;

    bpa_pkg::t_cfg              w_cfg;
    bpa_pkg::t_cmd              w_push_cmd;
    bpa_pkg::t_cmd              w_pop_cmd;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_q_full;
    logic                       w_q_empty;
    logic [1:0]                 w_status;
    logic [bpa_pkg::ADDR_W-1:0] w_unit_address;
    logic [bpa_pkg::IDX_W-1:0]  w_unit_index;
    logic [bpa_pkg::CNT_W-1:0]  w_used_units;

    // config port never stalls; writes are expected only while the block is idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= '0;
            r_unit_bytes   <= bpa_pkg::UNIT_RESET;
            r_units_in_use <= bpa_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpa_pkg::REG_POOL_BASE:    r_pool_base    <= i_cfg_data;
                bpa_pkg::REG_UNIT_BYTES:   r_unit_bytes   <= i_cfg_data[bpa_pkg::UNIT_W-1:0];
                bpa_pkg::REG_UNITS_IN_USE: r_units_in_use <= i_cfg_data[bpa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective values: zero unit size acts as one, capacity clamps at max
    always_comb begin
        w_cfg.base = r_pool_base;
        w_cfg.unit = (r_unit_bytes == '0) ? bpa_pkg::UNIT_W'(1) : r_unit_bytes;
        w_cfg.cap  = (r_units_in_use > bpa_pkg::CNT_W'(bpa_pkg::MAX_UNITS))
                   ? bpa_pkg::CNT_W'(bpa_pkg::MAX_UNITS) : r_units_in_use;
    end

    bpa_front u_front (
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_req_type     (i_s_tuser),
        .i_free_address (i_s_tdata[47:0]),
        .i_free_index   (i_s_tdata[55:48]),
        .i_cfg          (w_cfg),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    bpa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .o_full      (w_q_full),
        .o_empty     (w_q_empty),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_cmd)
    );

    bpa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_empty      (w_q_empty),
        .i_cmd          (w_pop_cmd),
        .o_pop          (w_pop),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_status       (w_status),
        .o_unit_address (w_unit_address),
        .o_unit_index   (w_unit_index),
        .o_used_units   (w_used_units)
    );

    assign o_m_tdata = {7'd0, w_used_units, w_unit_index, w_unit_address};
    assign o_m_tuser = w_status;

    // any error result carries zero address and zero index
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != bpa_pkg::ST_OK) |-> o_m_tdata[55:0] == 56'd0)
        else $error("error result with nonzero address or index");

    // used count never exceeds MAX_UNITS, the largest pool
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[64:56] <= 9'(bpa_pkg::MAX_UNITS))
        else $error("used count above pool size");

    // a full-pool result never reports an address
    a_full_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == bpa_pkg::ST_FULL) |-> o_m_tdata[47:0] == 48'd0)
        else $error("full result with address");

    // queue never takes a command while full
    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !o_s_tready && !w_push)
        else $error("push into full queue");

endmodule

FILE: tb/bpa_checker.sv
// Result checker for the bitmap pool allocator: mirrors the free map and compares results.
module bpa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [55:0]                   i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [71:0]                   i_m_tdata,
    input  logic [1:0]                    i_m_tuser,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0]                   i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct {
        bpa_pkg::t_status           status;
        logic [bpa_pkg::ADDR_W-1:0] addr;
        logic [bpa_pkg::IDX_W-1:0]  idx;
        logic [bpa_pkg::CNT_W-1:0]  used;
    } t_outcome;

    // mirrored allocator state and registers
    logic [bpa_pkg::MAX_UNITS-1:0] free_map;
    logic [bpa_pkg::CNT_W-1:0]     used_cnt;
    logic [bpa_pkg::ADDR_W-1:0]    pool_base;
    logic [bpa_pkg::UNIT_W-1:0]    unit_sz;
    logic [bpa_pkg::CNT_W-1:0]     cap_reg;

    t_outcome outcome_q[$];
    int       err_count = 0;

    assign o_errors = err_count;

    function automatic void release_unit(int unsigned k);
        if (!free_map[k]) begin
            free_map[k] = 1'b1;
            if (used_cnt != '0)
                used_cnt = used_cnt - 1'b1;
        end
    endfunction

    // grant / release one request against the mirrored map
    function automatic t_outcome apply_request(bpa_pkg::t_req req, logic [47:0] addr,
                                               logic [7:0] fidx);
        t_outcome    o;
        int unsigned cap;
        int          found;
        int          i;
        logic [63:0] ueff;
        logic [63:0] span;
        logic [63:0] k;
        o.status = bpa_pkg::ST_OK;
        o.addr   = '0;
        o.idx    = '0;
        cap      = (cap_reg > bpa_pkg::MAX_UNITS) ? bpa_pkg::MAX_UNITS : cap_reg;
        ueff     = (unit_sz == '0) ? 64'd1 : 64'(unit_sz);
        case (req)
            bpa_pkg::REQ_ALLOC: begin
                found = -1;
                for (i = 0; i < cap; i++)
                    if (found < 0 && free_map[i])
                        found = i;
                if (found < 0) begin
                    o.status = bpa_pkg::ST_FULL;
                end else begin
                    free_map[found] = 1'b0;
                    used_cnt        = used_cnt + 1'b1;
                    o.addr          = 48'(64'(pool_base) + 64'(found) * ueff);
                    o.idx           = 8'(found);
                end
            end
            bpa_pkg::REQ_FREE_ADDR: begin
                span = 64'(cap) * ueff;
                if (addr < pool_base || (64'(addr) - 64'(pool_base)) >= span) begin
                    o.status = bpa_pkg::ST_ADDR_RANGE;
                end else begin
                    k = (64'(addr) - 64'(pool_base)) / ueff;
                    release_unit(int'(k));
                    o.idx = k[7:0];
                end
            end
            bpa_pkg::REQ_FREE_IDX: begin
                if (fidx >= cap) begin
                    o.status = bpa_pkg::ST_IDX_RANGE;
                end else begin
                    release_unit(fidx);
                    o.idx = fidx;
                end
            end
            default: begin
                free_map = '1;
                used_cnt = '0;
            end
        endcase
        o.used = used_cnt;
        return o;
    endfunction

    task automatic check_result();
        t_outcome want;
        t_outcome got;
        logic     bad;
        got.status = bpa_pkg::t_status'(i_m_tuser);
        got.addr   = i_m_tdata[47:0];
        got.idx    = i_m_tdata[55:48];
        got.used   = i_m_tdata[64:56];
        if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result: status %0d addr %h idx %0d used %0d",
                     $time, got.status, got.addr, got.idx, got.used);
            err_count++;
        end else begin
            want = outcome_q.pop_front();
            bad  = 1'b0;
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                bad = 1'b1;
            end
            if (got.addr !== want.addr) begin
                $display("%0t: unit_address expected %h, got %h", $time, want.addr, got.addr);
                bad = 1'b1;
            end
            if (got.idx !== want.idx) begin
                $display("%0t: unit_index expected %0d, got %0d", $time, want.idx, got.idx);
                bad = 1'b1;
            end
            if (got.used !== want.used) begin
                $display("%0t: used_units expected %0d, got %0d", $time, want.used, got.used);
                bad = 1'b1;
            end
            if (i_m_tdata[71:65] !== '0) begin
                $display("%0t: tdata pad expected 0, got %h", $time, i_m_tdata[71:65]);
                bad = 1'b1;
            end
            if (bad)
                err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            free_map  = '1;
            used_cnt  = '0;
            pool_base = '0;
            unit_sz   = bpa_pkg::UNIT_RESET;
            cap_reg   = bpa_pkg::CAP_RESET;
            outcome_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bpa_pkg::REG_POOL_BASE:    pool_base = i_cfg_data;
                    bpa_pkg::REG_UNIT_BYTES:   unit_sz   = i_cfg_data[bpa_pkg::UNIT_W-1:0];
                    bpa_pkg::REG_UNITS_IN_USE: cap_reg   = i_cfg_data[bpa_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                outcome_q.push_back(apply_request(bpa_pkg::t_req'(i_s_tuser),
                                                  i_s_tdata[47:0], i_s_tdata[55:48]));
        end
        o_pending = outcome_q.size();
    end

endmodule

FILE: tb/bitmap_pool_allocator_top_tb.sv
// Testbench top for the bitmap pool allocator: stimulus, handshake pacing and verdict.
module bitmap_pool_allocator_top_tb;

    // cycles with no handshake on any channel before the run is declared hung;
    // worst honest gap is a divide plus a long receiver stall
    localparam int IDLE_LIMIT = 2000;
    // index outside the register map; a write there must change nothing
    localparam logic [bpa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [55:0]                   i_s_tdata;   // [47:0] free_address, [55:48] free_index
    logic [1:0]                    i_s_tuser;   // [1:0] req_type
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [71:0]                   o_m_tdata;   // [47:0] unit_address, [55:48] unit_index,
                                                // [64:56] used_units, [71:65] zero
    logic [1:0]                    o_m_tuser;   // [1:0] status
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [47:0]                   i_cfg_data;

    int errors;
    int pending;

    // stimulus-side copy of the registers, used to aim addresses and indexes
    logic [47:0] cur_base;
    logic [20:0] cur_unit;
    logic [8:0]  cur_cap;
    int          burst_left;
    int          idle_cycles;

    bitmap_pool_allocator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bpa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: picks a stall style for a random stretch, then another.
    // Style 0 never stalls, 1 is a coin toss, 2 is mostly stalled, 3 is periodic.
    initial begin
        int style;
        int stretch;
        int tick;
        i_m_tready = 1'b0;
        stretch    = 0;
        tick       = 0;
        style      = 0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                style   = $urandom_range(0, 3);
                stretch = $urandom_range(16, 80);
            end
            stretch--;
            tick++;
            case (style)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= 1'($urandom_range(0, 1));
                2:       i_m_tready <= ($urandom_range(0, 7) == 0);
                default: i_m_tready <= tick[2];
            endcase
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                    (i_cfg_valid && o_cfg_ready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    function automatic int unsigned cap_eff();
        return (cur_cap > bpa_pkg::MAX_UNITS) ? bpa_pkg::MAX_UNITS : cur_cap;
    endfunction

    // some byte inside unit k (k == capacity lands just past the pool)
    function automatic logic [47:0] pool_addr(int unsigned k);
        logic [63:0] ue;
        ue = (cur_unit == '0) ? 64'd1 : 64'(cur_unit);
        return 48'(64'(cur_base) + 64'(k) * ue + 64'($urandom_range(0, 32'(ue - 1))));
    endfunction

    // Sender: bursts of random length; a random gap opens each burst.
    // Called at a falling edge, returns at the falling edge after acceptance.
    task automatic send_item(bpa_pkg::t_req kind, logic [47:0] addr, logic [7:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {idx, addr};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // valid stays up across back-to-back writes; the last one drops it
    task automatic write_reg(logic [bpa_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val, bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
        case (idx)
            bpa_pkg::REG_POOL_BASE:    cur_base = val;
            bpa_pkg::REG_UNIT_BYTES:   cur_unit = val[20:0];
            bpa_pkg::REG_UNITS_IN_USE: cur_cap  = val[8:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [47:0] base, logic [20:0] ubytes, logic [8:0] cap);
        drain();
        write_reg(bpa_pkg::REG_POOL_BASE, base, 1'b0);
        write_reg(bpa_pkg::REG_UNIT_BYTES, 48'(ubytes), 1'b0);
        write_reg(bpa_pkg::REG_UNITS_IN_USE, 48'(cap), 1'b1);
    endtask

    // Mostly well-formed traffic (allocs and frees aimed into the pool) with
    // some boundary hits and fully random requests mixed in.
    task automatic random_item();
        int unsigned pick;
        int unsigned cap;
        logic [47:0] noise_a;
        logic [7:0]  noise_i;
        pick    = $urandom_range(0, 99);
        cap     = cap_eff();
        noise_a = {16'($urandom), $urandom};
        noise_i = 8'($urandom);
        if (pick < 40)
            send_item(bpa_pkg::REQ_ALLOC, noise_a, noise_i);
        else if (pick < 65 && cap > 0)
            send_item(bpa_pkg::REQ_FREE_ADDR, pool_addr($urandom_range(0, cap - 1)), noise_i);
        else if (pick < 85 && cap > 0)
            send_item(bpa_pkg::REQ_FREE_IDX, noise_a, 8'($urandom_range(0, cap - 1)));
        else if (pick < 88)
            send_item(bpa_pkg::REQ_CLEAR, noise_a, noise_i);
        else if (pick < 90)
            send_item(bpa_pkg::REQ_FREE_ADDR, pool_addr(cap), noise_i);
        else if (pick < 92)
            send_item(bpa_pkg::REQ_FREE_ADDR, cur_base - 48'd1, noise_i);
        else
            send_item(bpa_pkg::t_req'($urandom_range(0, 3)), noise_a, noise_i);
    endtask

    initial begin
        logic [47:0] b;
        logic [20:0] u;
        logic [8:0]  c;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = bpa_pkg::REQ_ALLOC;
        i_cfg_valid = 1'b0;
        i_cfg_index = bpa_pkg::REG_POOL_BASE;
        i_cfg_data  = '0;
        cur_base    = '0;
        cur_unit    = 21'd64;
        cur_cap     = 9'd256;
        burst_left  = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: base 0, 64-byte units, 256 units
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_ALLOC, '1, '1);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'd127, '0);       // last byte of unit 1
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'd64, '0);        // unit 1 already free
        send_item(bpa_pkg::REQ_FREE_IDX, '0, 8'd0);
        send_item(bpa_pkg::REQ_FREE_IDX, '1, 8'd255);         // top index, never used
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'd16384, '0);     // first byte past the pool
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'hFFFF_FFFF_FFFF, '0);
        send_item(bpa_pkg::REQ_CLEAR, '0, '0);

        // empty pool, zero unit size
        configure(48'hFFFF_FFFF_FFFF, 21'd0, 9'd0);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'hFFFF_FFFF_FFFF, '0);
        send_item(bpa_pkg::REQ_FREE_IDX, '0, 8'd0);

        // oversized capacity clamps; one-byte units at the top wrap to zero
        configure(48'hFFFF_FFFF_FFFF, 21'd0, 9'd511);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'hFFFF_FFFF_FFFF, '0);
        send_item(bpa_pkg::REQ_FREE_ADDR, 48'd0, '0);         // below the base

        // largest units, two of them, filled up, then capacity cut to one
        configure(48'h1234_5678_9ABC, 21'h1F_FFFF, 9'd2);
        send_item(bpa_pkg::REQ_CLEAR, '0, '0);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);                // full
        drain();
        write_reg(bpa_pkg::REG_UNITS_IN_USE, 48'd1, 1'b0);
        write_reg(REG_SPARE, {16'($urandom), $urandom}, 1'b1);
        send_item(bpa_pkg::REQ_FREE_IDX, '0, 8'd1);           // unit 1 now out of reach
        send_item(bpa_pkg::REQ_ALLOC, '0, '0);                // still full, count holds 2
        send_item(bpa_pkg::REQ_CLEAR, '0, '0);                // frees the stranded unit too

        // random phases; no clear between them, so stale units carry over
        for (int ph = 0; ph < 7; ph++) begin
            case ($urandom_range(0, 2))
                0:       b = '0;
                1:       b = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4096));
                default: b = {16'($urandom), $urandom};
            endcase
            case ($urandom_range(0, 3))
                0:       u = '0;
                1:       u = 21'd1;
                2:       u = 21'($urandom_range(2, 200));
                default: u = 21'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       c = 9'd256;
                1:       c = 9'($urandom_range(257, 511));
                2:       c = 9'd0;
                3:       c = 9'($urandom_range(1, 256));
                default: c = 9'($urandom_range(1, 40));
            endcase
            if (ph == 0) begin
                u = 21'h1F_FFFF;
                c = 9'd256;
            end
            configure(b, u, c);
            repeat (100) random_item();
        end

        drain();
        // longest back-end latency plus margin, to catch stray results
        repeat (16) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: bitmap_pool_allocator_top.f
src/bpa_pkg.sv
src/bpa_front.sv
src/bpa_queue.sv
src/bpa_back.sv
src/bitmap_pool_allocator_top.sv
tb/bpa_checker.sv
tb/bitmap_pool_allocator_top_tb.sv
